FILE: sv/dtlv_pkg.sv
`timescale 1ns / 1ps

package dtlv_pkg;

   // field widths fixed by the element format
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 32;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 3;
   localparam int HDR_W    = 3;

   // expected kind register codes
   localparam logic [KIND_W-1:0] KIND_ANY      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SEQUENCE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INTEGER  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BITS     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_OID      = 3'd4;
   localparam logic [KIND_W-1:0] KIND_STRING   = 3'd5;

   // tag bytes
   localparam logic [BYTE_W-1:0] TAG_SEQUENCE  = 8'h30;
   localparam logic [BYTE_W-1:0] TAG_INTEGER   = 8'h02;
   localparam logic [BYTE_W-1:0] TAG_BITS      = 8'h03;
   localparam logic [BYTE_W-1:0] TAG_OID       = 8'h06;
   localparam logic [BYTE_W-1:0] TAG_UTF8      = 8'h0C;
   localparam logic [BYTE_W-1:0] TAG_PRINTABLE = 8'h13;
   localparam logic [BYTE_W-1:0] TAG_T61       = 8'h14;
   localparam logic [BYTE_W-1:0] TAG_IA5       = 8'h16;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHORT     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FORM  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_MISMATCH  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY_BIT = 3'd5;

   // smallest buffer for a header
   localparam logic [LEN_W-1:0] MIN_AVAIL      = 32'd2;
   localparam logic [LEN_W-1:0] MIN_AVAIL_BITS = 32'd3;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LEN1,
      PH_LONG
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic              first;
      logic [LEN_W-1:0]  avail_len;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   tag;
      logic [LEN_W-1:0]    content_length;
      logic [HDR_W-1:0]    header_length;
      logic [HDR_W-1:0]    content_offset;
   } rsp_type;

   typedef logic [KIND_W-1:0] csr_type;

   // tag check against the configured kind; undefined kinds match nothing
   function automatic logic tag_matches(input logic [KIND_W-1:0] kind,
                                        input logic [BYTE_W-1:0] tag_byte);
      logic hit;
      hit = 1'b0;
      unique case (kind)
         KIND_ANY:      hit = 1'b1;
         KIND_SEQUENCE: hit = (tag_byte == TAG_SEQUENCE);
         KIND_INTEGER:  hit = (tag_byte == TAG_INTEGER);
         KIND_BITS:     hit = (tag_byte == TAG_BITS);
         KIND_OID:      hit = (tag_byte == TAG_OID);
         KIND_STRING:   hit = (tag_byte == TAG_UTF8) || (tag_byte == TAG_PRINTABLE) ||
                              (tag_byte == TAG_T61) || (tag_byte == TAG_IA5);
         default:       hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

FILE: sv/dtlv_stream_if.sv
`timescale 1ns / 1ps

interface dtlv_stream_if #(parameter type data_type = logic);
   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/der_tlv_header_parser_core.sv
`timescale 1ns / 1ps

// channel  | dir | payload                                  | accepted when
// ---------+-----+------------------------------------------+------------------------
// req_if   | in  | byte_value, first, avail_len             | req valid && ready
// rsp_if   | out | status, tag, content_length, header_     | rsp valid && ready
//          |     | length, content_offset                   |
// csr_if   | in  | expected_kind (3 bits)                   | csr valid && ready
//
// one byte request per cycle while the response is not stalled; each byte
// passes the input register and the byte-step logic into the result register.
// a byte that neither completes a header nor ends it in an error gives nothing.
// synchronous active-high reset clears the header state, kind and valids.
// a stalled response holds the result register; the input register still
// takes one more byte, then req ready follows rsp ready.

module der_tlv_header_parser_core #(
   parameter int MAX_LENGTH_BYTES = 4
) (
   input  logic          clock,
   input  logic          reset,
   dtlv_stream_if.sink   req_if,
   dtlv_stream_if.source rsp_if,
   dtlv_stream_if.sink   csr_if
);

   dtlv_pkg::csr_type expected_kind;
   logic              item_valid;
   logic              item_take;
   dtlv_pkg::req_type item_data;

   // kind register
   dtlv_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_if.valid),
      .csr_ready    (csr_if.ready),
      .csr_data     (csr_if.data),
      .expected_kind(expected_kind)
   );

   // input register
   dtlv_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .req_data  (req_if.data),
      .item_valid(item_valid),
      .item_take (item_take),
      .item_data (item_data)
   );

   // header decode and result register
   dtlv_parse #(
      .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .expected_kind(expected_kind),
      .item_valid   (item_valid),
      .item_take    (item_take),
      .item_data    (item_data),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .rsp_data     (rsp_if.data)
   );

endmodule

FILE: sv/dtlv_csr.sv
`timescale 1ns / 1ps

module dtlv_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  dtlv_pkg::csr_type csr_data,
   output dtlv_pkg::csr_type expected_kind
);

   dtlv_pkg::csr_type kind_ff;

   // register always takes a write
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= dtlv_pkg::KIND_ANY;
      end else if (csr_valid) begin
         kind_ff <= csr_data;
      end
   end

   assign expected_kind = kind_ff;

endmodule

FILE: sv/dtlv_in_reg.sv
`timescale 1ns / 1ps

module dtlv_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dtlv_pkg::req_type req_data,
   output logic             item_valid,
   input  logic             item_take,
   output dtlv_pkg::req_type item_data
);

   logic              valid_ff;
   dtlv_pkg::req_type data_ff;
   logic              load;

   // accept a request when the register is empty or drains this cycle
   assign req_ready = !valid_ff || item_take;
   assign load      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (item_take) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

FILE: sv/dtlv_parse.sv
`timescale 1ns / 1ps

module dtlv_parse #(
   parameter int MAX_LENGTH_BYTES = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  dtlv_pkg::csr_type  expected_kind,
   input  logic              item_valid,
   output logic              item_take,
   input  dtlv_pkg::req_type  item_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dtlv_pkg::rsp_type  rsp_data
);

   localparam int LEFT_W = $clog2(MAX_LENGTH_BYTES + 1);
   localparam int HC_W   = $clog2(MAX_LENGTH_BYTES + 3);
   localparam int LW     = dtlv_pkg::LEN_W;
   localparam int BW     = dtlv_pkg::BYTE_W;

   dtlv_pkg::phase_type phase_ff, phase_in;
   logic [BW-1:0]       tag_ff, tag_in;
   logic [LEFT_W-1:0]   left_ff, left_in;
   logic [LW-1:0]       accum_ff, accum_in;
   logic [HC_W-1:0]     hcount_ff, hcount_in;
   logic [LW-1:0]       avail_ff, avail_in;

   logic                out_valid_ff;
   dtlv_pkg::rsp_type   out_data_ff;

   logic                emit;
   dtlv_pkg::rsp_type   result;
   logic                fin_req;
   logic [HC_W-1:0]     fin_hc;
   logic [LW-1:0]       fin_acc;
   logic [LW:0]         fin_total;
   logic                bits_kind;
   logic [6:0]          n_bytes;
   logic [LEFT_W-1:0]   left_dec;

   // the stage moves when the result register is free or drains now
   assign item_take = item_valid && (!out_valid_ff || rsp_ready);

   // header state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= dtlv_pkg::PH_IDLE;
         tag_ff    <= '0;
         left_ff   <= '0;
         accum_ff  <= '0;
         hcount_ff <= '0;
         avail_ff  <= '0;
      end else if (item_take) begin
         phase_ff  <= phase_in;
         tag_ff    <= tag_in;
         left_ff   <= left_in;
         accum_ff  <= accum_in;
         hcount_ff <= hcount_in;
         avail_ff  <= avail_in;
      end
   end

   // one byte step: next state and result
   always_comb begin
      phase_in  = phase_ff;
      tag_in    = tag_ff;
      left_in   = left_ff;
      accum_in  = accum_ff;
      hcount_in = hcount_ff;
      avail_in  = avail_ff;
      emit      = 1'b0;
      fin_req   = 1'b0;
      fin_hc    = hcount_ff;
      fin_acc   = accum_ff;
      fin_total = '0;
      result    = '0;
      bits_kind = (expected_kind == dtlv_pkg::KIND_BITS);
      n_bytes   = item_data.byte_value[6:0];
      left_dec  = (left_ff != '0) ? left_ff - LEFT_W'(1) : left_ff;

      if (item_data.first) begin
         // tag byte opens a new element
         tag_in    = item_data.byte_value;
         avail_in  = item_data.avail_len;
         hcount_in = HC_W'(1);
         accum_in  = '0;
         left_in   = '0;
         if (item_data.avail_len <
             (bits_kind ? dtlv_pkg::MIN_AVAIL_BITS : dtlv_pkg::MIN_AVAIL)) begin
            emit          = 1'b1;
            result.status = dtlv_pkg::STATUS_SHORT;
         end else if (!dtlv_pkg::tag_matches(expected_kind, item_data.byte_value)) begin
            emit          = 1'b1;
            result.status = dtlv_pkg::STATUS_MISMATCH;
         end else begin
            phase_in = dtlv_pkg::PH_LEN1;
         end
      end else begin
         unique case (phase_ff)
            dtlv_pkg::PH_LEN1: begin
               hcount_in = HC_W'(2);
               if (!item_data.byte_value[7]) begin
                  // short form
                  accum_in = LW'(item_data.byte_value);
                  fin_req  = 1'b1;
                  fin_hc   = HC_W'(2);
                  fin_acc  = LW'(item_data.byte_value);
               end else if (n_bytes == 7'd0 || n_bytes > 7'(MAX_LENGTH_BYTES)) begin
                  emit          = 1'b1;
                  result.status = dtlv_pkg::STATUS_BAD_FORM;
               end else if ({1'b0, avail_ff} < (33'(n_bytes) + 33'd2)) begin
                  emit          = 1'b1;
                  result.status = dtlv_pkg::STATUS_SHORT;
               end else begin
                  left_in  = LEFT_W'(n_bytes);
                  accum_in = '0;
                  phase_in = dtlv_pkg::PH_LONG;
               end
            end
            dtlv_pkg::PH_LONG: begin
               // long form, most significant byte first
               hcount_in = hcount_ff + HC_W'(1);
               accum_in  = {accum_ff[LW-BW-1:0], item_data.byte_value};
               left_in   = left_dec;
               if (left_dec == '0) begin
                  fin_req = 1'b1;
                  fin_hc  = hcount_ff + HC_W'(1);
                  fin_acc = {accum_ff[LW-BW-1:0], item_data.byte_value};
               end
            end
            default: begin
               phase_in = dtlv_pkg::PH_IDLE;
            end
         endcase
      end

      // header complete: overflow check at 33 bits, bit-string adjust
      if (fin_req) begin
         emit      = 1'b1;
         fin_total = (LW+1)'(fin_hc) + {1'b0, fin_acc};
         if (fin_total > {1'b0, avail_ff}) begin
            result.status = dtlv_pkg::STATUS_OVERFLOW;
         end else if (bits_kind) begin
            if (fin_acc == '0) begin
               result.status = dtlv_pkg::STATUS_EMPTY_BIT;
            end else begin
               result.status         = dtlv_pkg::STATUS_OK;
               result.content_length = fin_acc - LW'(1);
               result.header_length  = dtlv_pkg::HDR_W'(fin_hc);
               result.content_offset = dtlv_pkg::HDR_W'(fin_hc) + dtlv_pkg::HDR_W'(1);
            end
         end else begin
            result.status         = dtlv_pkg::STATUS_OK;
            result.content_length = fin_acc;
            result.header_length  = dtlv_pkg::HDR_W'(fin_hc);
            result.content_offset = dtlv_pkg::HDR_W'(fin_hc);
         end
      end

      if (emit) begin
         phase_in   = dtlv_pkg::PH_IDLE;
         result.tag = tag_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (item_take && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && emit) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

FILE: sv/dtlv_checker.sv
`timescale 1ns / 1ps

module dtlv_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dtlv_pkg::rsp_type rsp_data
);

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   // an error result carries no lengths
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != dtlv_pkg::STATUS_OK |->
         rsp_data.content_length == '0 && rsp_data.header_length == '0 &&
         rsp_data.content_offset == '0)
      else $error("error response with nonzero lengths");

   // offset is the header length, or one more for a bit string
   a_ok_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == dtlv_pkg::STATUS_OK |->
         rsp_data.content_offset == rsp_data.header_length ||
         rsp_data.content_offset == rsp_data.header_length + 3'd1)
      else $error("content offset does not follow header length");

endmodule

bind der_tlv_header_parser_core dtlv_checker u_dtlv_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .rsp_data (rsp_if.data)
);
